// ----- rtl/tts_pkg.sv -----
`default_nettype none
package tts_pkg;

  localparam int unsigned DefMaxRows  = 64;
  localparam int unsigned DefFracBits = 16;
  localparam int unsigned DataW       = 32;
  localparam int unsigned RowIdxW     = 6;

  typedef struct packed {
    logic              last_row;
    logic signed [31:0] rhs;
    logic signed [31:0] super_diag;
    logic signed [31:0] main_diag;
    logic signed [31:0] sub_diag;
  } row_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_GDIV, ST_GMUL, ST_GSCL, ST_GSUB, ST_CHECK, ST_XMUL, ST_XSCL,
    ST_XSUB, ST_XDIV, ST_BRD, ST_BMUL, ST_BSCL, ST_BSUB, ST_BEMIT
  } core_state_e;

  localparam logic signed [31:0] QMax = 32'sh7fff_ffff;
  localparam logic signed [31:0] QMin = 32'sh8000_0000;

  function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7fff_ffff) r = QMax;
    else if (v < -64'sh0000_0000_8000_0000) r = QMin;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) r = v[32] ? QMin : QMax;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/tts_ram.sv -----
`default_nettype none
module tts_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

// ----- rtl/tts_front.sv -----
`default_nettype none
module tts_front
  import tts_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output      logic in_ready_o,
  input  wire row_t in_row_i,
  output      logic out_valid_o,
  input  wire logic out_pop_i,
  output      row_t out_row_o
);
  // Two-entry queue of rows between the stream port and the solver core.
  row_t       slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_row_o   = slot_q[rd_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_pop_i && out_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_q] <= in_row_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ----- rtl/tts_div.sv -----
`default_nettype none
module tts_div
  import tts_pkg::*;
#(
  parameter int unsigned FracBits = DefFracBits
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [31:0] num_i,
  input  wire logic signed [31:0] den_i,
  output      logic               busy_o,
  output      logic signed [31:0] quo_o
);
  // Restoring division of (num << FracBits) by den, one quotient bit a cycle.
  localparam int unsigned NW = 32 + FracBits;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] dvd_q;
  logic [31:0]   rem_q, den_q;
  logic          neg_q, busy_q;
  logic [CW-1:0] cnt_q;
  logic [32:0]   trial, diff;
  logic [31:0]   an, ad;

  assign an    = num_i[31] ? 32'(-num_i) : 32'(num_i);
  assign ad    = den_i[31] ? 32'(-den_i) : 32'(den_i);
  assign trial = {rem_q, dvd_q[NW-1]};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= {an, {FracBits{1'b0}}};
      rem_q <= '0;
      den_q <= ad;
      neg_q <= num_i[31] ^ den_i[31];
    end else if (busy_q) begin
      if (!diff[32]) begin
        rem_q <= diff[31:0];
        dvd_q <= {dvd_q[NW-2:0], 1'b1};
      end else begin
        rem_q <= trial[31:0];
        dvd_q <= {dvd_q[NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(NW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) busy_q <= 1'b0;
    end
  end

  assign busy_o = busy_q;

  always_comb begin
    if (!neg_q) begin
      quo_o = (dvd_q > NW'(32'h7fff_ffff)) ? QMax : dvd_q[31:0];
    end else begin
      quo_o = (dvd_q > NW'(33'h0_8000_0000)) ? QMin : 32'(-dvd_q[31:0]);
    end
  end
endmodule
`default_nettype wire

// ----- rtl/tts_core.sv -----
`default_nettype none
module tts_core
  import tts_pkg::*;
#(
  parameter int unsigned MaxRows  = DefMaxRows,
  parameter int unsigned FracBits = DefFracBits
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               row_valid_i,
  output      logic               row_pop_o,
  input  wire row_t               row_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic signed [31:0] out_sol_o,
  output      logic [5:0]         out_row_o,
  output      logic               out_last_o,
  output      logic               out_sing_o
);
  localparam int unsigned IW = $clog2(MaxRows);

  core_state_e        state_q, state_d;
  row_t               row_q;
  logic [IW-1:0]      cnt_q, j_q, i_q;
  logic               last_q, sing_seen_q;
  logic signed [31:0] pivot_q, psup_q, xprev_q, g_q, bet_q, num_q, mq_q;
  logic signed [63:0] mul_q;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_sh, mul_tz;

  logic               ov_q, olast_q, osing_q;
  logic signed [31:0] osol_q;
  logic [IW-1:0]      orow_q;
  logic               out_free;

  logic               div_start, div_busy;
  logic signed [31:0] div_num, div_den, div_quo;
  logic               ram_we, ram_re;
  logic [IW-1:0]      gam_raddr;
  logic signed [31:0] gam_rd, xs_rd, back_v;

  logic               load_out, end_run;
  logic signed [31:0] load_sol;
  logic [IW-1:0]      load_row;
  logic               load_last, load_sing;

  tts_div #(.FracBits(FracBits)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .busy_o(div_busy), .quo_o(div_quo)
  );

  tts_ram #(.Width(DataW), .Depth(MaxRows)) u_gamma (
    .clk_i, .we_i(ram_we), .waddr_i(j_q), .wdata_i(g_q),
    .re_i(ram_re), .raddr_i(gam_raddr), .rdata_o(gam_rd)
  );

  tts_ram #(.Width(DataW), .Depth(MaxRows)) u_xs (
    .clk_i, .we_i(ram_we), .waddr_i(j_q), .wdata_i(div_quo),
    .re_i(ram_re), .raddr_i(i_q), .rdata_o(xs_rd)
  );

  assign gam_raddr = i_q + IW'(1);
  assign out_free  = !ov_q || out_ready_i;

  always_comb begin
    unique case (state_q)
      ST_GMUL: begin mul_a = row_q.sub_diag; mul_b = g_q;     end
      ST_BMUL: begin mul_a = gam_rd;         mul_b = xprev_q; end
      default: begin mul_a = row_q.sub_diag; mul_b = xprev_q; end
    endcase
  end

  // Product scaled down by 2^FracBits, truncated toward zero.
  assign mul_sh = mul_q >>> FracBits;
  assign mul_tz = (mul_q[63] && (mul_q[FracBits-1:0] != '0)) ? mul_sh + 64'sd1 : mul_sh;
  assign back_v = sat33(33'(xs_rd) - 33'(mq_q));

  always_comb begin
    state_d   = state_q;
    row_pop_o = 1'b0;
    div_start = 1'b0;
    div_num   = num_q;
    div_den   = bet_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    load_out  = 1'b0;
    load_sol  = div_quo;
    load_row  = j_q;
    load_last = 1'b0;
    load_sing = 1'b0;
    end_run   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (row_valid_i) begin
          row_pop_o = 1'b1;
          if (sing_seen_q) begin
            end_run = row_i.last_row;
          end else if (cnt_q == '0) begin
            state_d = ST_CHECK;
          end else begin
            div_start = 1'b1;
            div_num   = psup_q;
            div_den   = pivot_q;
            state_d   = ST_GDIV;
          end
        end
      end
      ST_GDIV: if (!div_busy) state_d = ST_GMUL;
      ST_GMUL: state_d = ST_GSCL;
      ST_GSCL: state_d = ST_GSUB;
      ST_GSUB: state_d = ST_CHECK;
      ST_CHECK: begin
        if (bet_q == '0) begin
          if (out_free) begin
            load_out  = 1'b1;
            load_sol  = '0;
            load_last = 1'b1;
            load_sing = 1'b1;
            end_run   = last_q;
            state_d   = ST_IDLE;
          end
        end else if (j_q == '0) begin
          div_start = 1'b1;
          state_d   = ST_XDIV;
        end else begin
          state_d = ST_XMUL;
        end
      end
      ST_XMUL: state_d = ST_XSCL;
      ST_XSCL: state_d = ST_XSUB;
      ST_XSUB: begin
        div_start = 1'b1;
        div_num   = sat33(33'(num_q) - 33'(mq_q));
        state_d   = ST_XDIV;
      end
      ST_XDIV: begin
        if (!div_busy && (!last_q || out_free)) begin
          ram_we = 1'b1;
          if (!last_q) begin
            state_d = ST_IDLE;
          end else begin
            load_out  = 1'b1;
            load_last = (j_q == '0);
            end_run   = (j_q == '0);
            state_d   = (j_q == '0) ? ST_IDLE : ST_BRD;
          end
        end
      end
      ST_BRD: begin
        ram_re  = 1'b1;
        state_d = ST_BMUL;
      end
      ST_BMUL: state_d = ST_BSCL;
      ST_BSCL: state_d = ST_BSUB;
      ST_BSUB: state_d = ST_BEMIT;
      ST_BEMIT: begin
        if (out_free) begin
          load_out  = 1'b1;
          load_sol  = xprev_q;
          load_row  = i_q;
          load_last = (i_q == '0);
          end_run   = (i_q == '0);
          state_d   = (i_q == '0) ? ST_IDLE : ST_BRD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
    mq_q  <= sat64(mul_tz);
    if (state_q == ST_IDLE && row_pop_o) begin
      row_q  <= row_i;
      j_q    <= cnt_q;
      last_q <= row_i.last_row || (cnt_q == IW'(MaxRows - 1));
      num_q  <= sat33(-33'(row_i.rhs));
      bet_q  <= row_i.main_diag;
      g_q    <= '0;
    end
    if (state_q == ST_GDIV && !div_busy) g_q <= div_quo;
    if (state_q == ST_GSUB) bet_q <= sat33(33'(row_q.main_diag) - 33'(mq_q));
    if (state_q == ST_XDIV && ram_we) begin
      xprev_q <= div_quo;
      i_q     <= j_q - IW'(1);
    end
    if (state_q == ST_BSUB) xprev_q <= back_v;
    if (state_q == ST_BEMIT && out_free) i_q <= i_q - IW'(1);
    if (load_out) begin
      osol_q  <= load_sol;
      orow_q  <= load_row;
      olast_q <= load_last;
      osing_q <= load_sing;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      sing_seen_q <= 1'b0;
      pivot_q     <= '0;
      psup_q      <= '0;
      ov_q        <= 1'b0;
    end else begin
      if (load_out)         ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
      if (state_q == ST_CHECK && load_out && !last_q) sing_seen_q <= 1'b1;
      if (ram_we) begin
        pivot_q <= bet_q;
        psup_q  <= row_q.super_diag;
        if (!last_q) cnt_q <= j_q + IW'(1);
      end
      if (end_run) begin
        cnt_q       <= '0;
        sing_seen_q <= 1'b0;
        pivot_q     <= '0;
        psup_q      <= '0;
      end
    end
  end

  assign out_valid_o = ov_q;
  assign out_sol_o   = osol_q;
  assign out_row_o   = 6'(orow_q);
  assign out_last_o  = olast_q;
  assign out_sing_o  = osing_q;
endmodule
`default_nettype wire

// ----- rtl/tridiagonal_thomas_solver.sv -----
`default_nettype none
// Channel   Dir  Word
// s_axis    in   tdata: sub_diag, main_diag, super_diag, rhs; tlast: last_row
// m_axis    out  tdata: solution, row_index, 0 pad; tlast: last; tuser: singular
//
// Each row passes twice through the bit-serial divider; the first row needs one
// division only. Back substitution produces each word through store read,
// multiply, scale, subtract and output steps. Reset clears the state machine,
// queue pointers, row count, divider busy and output valid; stores need no clearing.
// A two-row queue at the input and an output register let either side stall.
module tridiagonal_thomas_solver
  import tts_pkg::*;
#(
  parameter int unsigned MAX_ROWS  = DefMaxRows,
  parameter int unsigned FRAC_BITS = DefFracBits
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output      logic         s_axis_tready_o,
  input  wire logic [127:0] s_axis_tdata_i,  // sub_diag, main_diag, super_diag, rhs
  input  wire logic         s_axis_tlast_i,  // last_row
  output      logic         m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  output      logic [39:0]  m_axis_tdata_o,  // solution, row_index, zero pad
  output      logic         m_axis_tlast_o,  // last
  output      logic         m_axis_tuser_o   // singular
);
  row_t               in_row, q_row;
  logic               q_valid, q_pop;
  logic signed [31:0] sol;
  logic [5:0]         row_idx;

  assign in_row = {s_axis_tlast_i, s_axis_tdata_i};

  tts_front u_front (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid_i), .in_ready_o(s_axis_tready_o),
    .in_row_i(in_row), .out_valid_o(q_valid), .out_pop_i(q_pop), .out_row_o(q_row)
  );

  tts_core #(.MaxRows(MAX_ROWS), .FracBits(FRAC_BITS)) u_core (
    .clk_i, .rst_ni, .row_valid_i(q_valid), .row_pop_o(q_pop), .row_i(q_row),
    .out_valid_o(m_axis_tvalid_o), .out_ready_i(m_axis_tready_i),
    .out_sol_o(sol), .out_row_o(row_idx), .out_last_o(m_axis_tlast_o),
    .out_sing_o(m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {2'b00, row_idx, sol};

`ifndef SYNTHESIS
  // A singular report is always the final word of its run and carries zero.
  a_sing_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o && (sol == '0))
    else $error("singular word without last or with nonzero solution");
  // The divider is never restarted while it is still iterating.
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    u_core.div_start |-> !u_core.div_busy)
    else $error("divider started while busy");
  // A row is taken from the queue only when the core is idle.
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid && (u_core.state_q == ST_IDLE))
    else $error("row popped outside idle");
`endif
endmodule
`default_nettype wire
